### rtl/u8dec_pkg.sv
// shared constants and types for the utf-8 stream decoder
// no dependencies
package u8dec_pkg;

    // longest accepted sequence, 4 to 6 bytes
    localparam int MAX_SEQ_BYTES = 6;

    localparam int CP_W   = 31;
    localparam int LEN_W  = 3;
    localparam int STAT_W = 2;
    localparam int BYTE_W = 8;

    // result data packed as code_point then seq_length, padded to bytes
    localparam int OUT_DATA_W = ((CP_W + LEN_W + 7) / 8) * 8;

    typedef logic [CP_W-1:0]   code_point_t;
    typedef logic [LEN_W-1:0]  seq_len_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // result status codes
    localparam status_t ST_CHAR    = 2'd0;
    localparam status_t ST_INVALID = 2'd1;
    localparam status_t ST_END     = 2'd2;

endpackage

### rtl/utf8_stream_decoder.sv
// utf-8 stream decoder (long forms up to six bytes), byte in, code point out
// depends on u8dec_pkg
//
// an input transfer passes through the input register, then the result register, to the master side
// throughput: one byte per cycle, limited only by the output register's handshake
// an input register feeds a single decode step that writes the result register
// reset (rst_n low, asynchronous) empties both registers and returns to idle
module utf8_stream_decoder
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  u8dec_pkg::byte_t                      s_axis_tdata,  // [7:0] data_byte
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [u8dec_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [30:0] code_point,
                                                                 // [33:31] seq_length, zero pad
    output u8dec_pkg::status_t                    m_axis_tuser   // [1:0] status
);
    import u8dec_pkg::*;

    byte_t       byte_reg;
    logic        byte_valid_reg;
    code_point_t partial_reg, partial_next;
    seq_len_t    remain_reg, remain_next;
    seq_len_t    size_reg, size_next;
    logic        out_valid_reg;
    code_point_t out_cp_reg, out_cp_next;
    seq_len_t    out_len_reg, out_len_next;
    status_t     out_stat_reg, out_stat_next;
    logic        emit;
    logic        out_free;

    // the decode step runs whenever the result register can take a value
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !byte_valid_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            byte_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            byte_reg <= s_axis_tdata;
        end
    end

    // decode one byte against the sequence state
    always_comb
    begin
        partial_next  = partial_reg;
        remain_next   = remain_reg;
        size_next     = size_reg;
        emit          = 1'b0;
        out_cp_next   = '0;
        out_len_next  = '0;
        out_stat_next = ST_CHAR;
        if (remain_reg != '0)
        begin
            // following byte: only its low six bits count
            partial_next = {partial_reg[CP_W-7:0], byte_reg[5:0]};
            remain_next  = remain_reg - 3'd1;
            if (remain_reg == 3'd1)
            begin
                emit         = 1'b1;
                out_cp_next  = partial_next;
                out_len_next = size_reg;
            end
        end
        else if (byte_reg == 8'h00)
        begin
            emit          = 1'b1;
            out_stat_next = ST_END;
        end
        else if (byte_reg inside {[8'h01:8'h7F]})
        begin
            partial_next = code_point_t'(byte_reg[6:0]);
            size_next    = 3'd1;
            emit         = 1'b1;
            out_cp_next  = partial_next;
            out_len_next = 3'd1;
        end
        else if (byte_reg inside {[8'hC0:8'hDF]})
        begin
            partial_next = code_point_t'(byte_reg[4:0]);
            size_next    = 3'd2;
            remain_next  = 3'd1;
        end
        else if (byte_reg inside {[8'hE0:8'hEF]})
        begin
            partial_next = code_point_t'(byte_reg[3:0]);
            size_next    = 3'd3;
            remain_next  = 3'd2;
        end
        else if (byte_reg inside {[8'hF0:8'hF7]})
        begin
            partial_next = code_point_t'(byte_reg[2:0]);
            size_next    = 3'd4;
            remain_next  = 3'd3;
        end
        else if ((byte_reg inside {[8'hF8:8'hFB]}) && (MAX_SEQ_BYTES > 4))
        begin
            partial_next = code_point_t'(byte_reg[1:0]);
            size_next    = 3'd5;
            remain_next  = 3'd4;
        end
        else if ((byte_reg inside {[8'hFC:8'hFD]}) && (MAX_SEQ_BYTES > 5))
        begin
            partial_next = code_point_t'(byte_reg[0]);
            size_next    = 3'd6;
            remain_next  = 3'd5;
        end
        else
        begin
            // stray continuation or unusable lead
            partial_next  = '0;
            size_next     = '0;
            emit          = 1'b1;
            out_stat_next = ST_INVALID;
        end
    end

    // sequence state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            remain_reg    <= '0;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (byte_valid_reg)
            begin
                partial_reg <= partial_next;
                remain_reg  <= remain_next;
                size_reg    <= size_next;
            end
            out_valid_reg <= byte_valid_reg && emit;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_free && byte_valid_reg && emit)
        begin
            out_cp_reg   <= out_cp_next;
            out_len_reg  <= out_len_next;
            out_stat_reg <= out_stat_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-CP_W-LEN_W){1'b0}}, out_len_reg, out_cp_reg};
    assign m_axis_tuser  = out_stat_reg;

    // checks on the decode logic
    a_remain_range: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg <= seq_len_t'(MAX_SEQ_BYTES - 1))
        else $error("bytes remaining beyond longest sequence");

    a_nonchar_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stat_reg != ST_CHAR) |-> (out_cp_reg == '0 && out_len_reg == '0))
        else $error("invalid or end result carries data");

    a_char_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stat_reg == ST_CHAR) |->
            (out_len_reg != '0 && out_len_reg <= seq_len_t'(MAX_SEQ_BYTES)))
        else $error("character result with bad length");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(byte_valid_reg))
        else $error("result without a decoded byte");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (out_stat_reg == ST_CHAR || out_stat_reg == ST_INVALID || out_stat_reg == ST_END))
        else $error("undefined status code");

endmodule

### tb/testbench.sv
// self-checking testbench for utf8_stream_decoder: byte stream in, code points out
// depends on u8dec_pkg and the decoder rtl; carries its own model of the decode steps
module testbench;
    import u8dec_pkg::*;

    // longest form the decoder accepts, clamped to 4..6 like the rtl parameter
    localparam int LONGEST = (MAX_SEQ_BYTES <= 4) ? 4 :
                             ((MAX_SEQ_BYTES >= 6) ? 6 : MAX_SEQ_BYTES);
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_BYTES = 1050;

    typedef struct packed {
        code_point_t code_point;
        seq_len_t    seq_length;
        status_t     status;
    } decoded_char_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    byte_t                 s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    status_t               m_axis_tuser;

    // decoder model state
    code_point_t     gathered_bits;
    seq_len_t        bytes_left;
    seq_len_t        char_size;
    decoded_char_t   pending_chars[$];

    int error_count;
    int bytes_sent;
    int idle_cycles;
    int stall_left;
    int hold_request;
    bit sender_throttle;
    bit receiver_throttle;

    utf8_stream_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // one decode step on an accepted byte, queues the character, end or invalid result it produces
    function automatic void decode_byte(byte_t data_in);
        decoded_char_t result;
        bit            produced;
        code_point_t   top_bits;
        seq_len_t      lead_len;
        produced = 1'b0;
        result   = '0;
        top_bits = '0;
        lead_len = '0;
        if (bytes_left != 0)
        begin
            // following byte: low six bits only, marker bits ignored
            gathered_bits = {gathered_bits[CP_W-7:0], data_in[5:0]};
            bytes_left    = bytes_left - 1'b1;
            if (bytes_left == 0)
            begin
                result.code_point = gathered_bits;
                result.seq_length = char_size;
                result.status     = ST_CHAR;
                produced          = 1'b1;
            end
        end
        else if (data_in == 8'h00)
        begin
            result.status = ST_END;
            produced      = 1'b1;
        end
        else
        begin
            // lead byte classification
            if ((data_in & 8'h80) == 8'h00)
            begin
                top_bits = code_point_t'(data_in);
                lead_len = 3'd1;
            end
            else if ((data_in & 8'hE0) == 8'hC0)
            begin
                top_bits = code_point_t'(data_in & 8'h1F);
                lead_len = 3'd2;
            end
            else if ((data_in & 8'hF0) == 8'hE0)
            begin
                top_bits = code_point_t'(data_in & 8'h0F);
                lead_len = 3'd3;
            end
            else if ((data_in & 8'hF8) == 8'hF0)
            begin
                top_bits = code_point_t'(data_in & 8'h07);
                lead_len = 3'd4;
            end
            else if ((data_in & 8'hFC) == 8'hF8 && LONGEST > 4)
            begin
                top_bits = code_point_t'(data_in & 8'h03);
                lead_len = 3'd5;
            end
            else if ((data_in & 8'hFE) == 8'hFC && LONGEST > 5)
            begin
                top_bits = code_point_t'(data_in & 8'h01);
                lead_len = 3'd6;
            end

            if (lead_len == 0)
            begin
                gathered_bits = '0;
                char_size     = '0;
                result.status = ST_INVALID;
                produced      = 1'b1;
            end
            else
            begin
                gathered_bits = top_bits;
                char_size     = lead_len;
                bytes_left    = lead_len - 1'b1;
                if (bytes_left == 0)
                begin
                    result.code_point = gathered_bits;
                    result.seq_length = char_size;
                    result.status     = ST_CHAR;
                    produced          = 1'b1;
                end
            end
        end
        if (produced)
            pending_chars.push_back(result);
    endfunction

    // offer one byte from a falling edge and wait for its transfer
    task automatic send_byte(input byte_t data_in);
        int gap;
        gap = sender_throttle ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data_in;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_byte(data_in);
        bytes_sent++;
        @(negedge clk);
    endtask

    // one well-formed character of the given length with random content
    task automatic send_char(input int len);
        byte_t lead;
        case (len)
            1: lead = byte_t'($urandom_range(1, 127));
            2: lead = 8'hC0 | byte_t'($urandom_range(0, 31));
            3: lead = 8'hE0 | byte_t'($urandom_range(0, 15));
            4: lead = 8'hF0 | byte_t'($urandom_range(0, 7));
            5: lead = 8'hF8 | byte_t'($urandom_range(0, 3));
            default: lead = 8'hFC | byte_t'($urandom_range(0, 1));
        endcase
        send_byte(lead);
        for (int i = 1; i < len; i++)
            send_byte(8'h80 | byte_t'($urandom_range(0, 63)));
    endtask

    // receiver side: random stalls plus an optional long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left == 0 && receiver_throttle && $urandom_range(0, 2) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest predicted character
    always @(posedge clk)
    begin
        decoded_char_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected result: code_point %0h seq_length %0d status %0d",
                       m_axis_tdata[CP_W-1:0], m_axis_tdata[CP_W+LEN_W-1:CP_W], m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (m_axis_tdata[CP_W-1:0] !== want.code_point)
                begin
                    $error("code_point: expected %0h, got %0h",
                           want.code_point, m_axis_tdata[CP_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[CP_W+LEN_W-1:CP_W] !== want.seq_length)
                begin
                    $error("seq_length: expected %0d, got %0d",
                           want.seq_length, m_axis_tdata[CP_W+LEN_W-1:CP_W]);
                    error_count++;
                end
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ascii range ends and end of string
    task automatic test_ascii_and_end();
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h01);
    endtask

    // every multi-byte length from two to six, all-ones payloads but for an all-zeros four-byte one
    task automatic test_long_forms();
        send_byte(8'hDF); send_byte(8'hBF);
        send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBF);
        send_byte(8'hF0); send_byte(8'h80); send_byte(8'h80); send_byte(8'h80);
        send_byte(8'hFB);
        repeat (4) send_byte(8'hBF);
        send_byte(8'hFD);
        repeat (5) send_byte(8'hBF);
    endtask

    // bytes that cannot lead a sequence
    task automatic test_invalid_leads();
        send_byte(8'h80);
        send_byte(8'hBF);
        send_byte(8'hFE);
        send_byte(8'hFF);
    endtask

    // nul and lead-like bytes in following position count as data
    task automatic test_malformed_following();
        send_byte(8'hC3); send_byte(8'h00);
        send_byte(8'hE1); send_byte(8'hFF); send_byte(8'hC0);
    endtask

    // mostly well-formed characters, some noise and cut-short sequences
    task automatic test_random_stream();
        int start;
        int r;
        int len;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            // change the idling pattern now and then, including stretches with none
            if ($urandom_range(0, 99) == 0)
            begin
                sender_throttle   = 1'($urandom_range(0, 1));
                receiver_throttle = 1'($urandom_range(0, 1));
            end
            r = $urandom_range(0, 99);
            if (r < 12)
                send_byte(byte_t'($urandom_range(0, 255)));
            else if (r < 20)
            begin
                // ascii character, then a byte from C0 to FF with zero up to LONGEST-2 following bytes
                len = $urandom_range(2, LONGEST);
                send_char(1);
                send_byte(8'hC0 | byte_t'($urandom_range(0, 63)));
                repeat ($urandom_range(0, len - 2))
                    send_byte(8'h80 | byte_t'($urandom_range(0, 63)));
            end
            else
                send_char($urandom_range(1, LONGEST));
        end
    endtask

    // back to back transfers with no idling on either side
    task automatic test_full_rate();
        sender_throttle   = 1'b0;
        receiver_throttle = 1'b0;
        repeat (60)
            send_char($urandom_range(1, LONGEST));
    endtask

    // receiver holds off for a long stretch while bytes keep coming
    task automatic test_backpressure();
        sender_throttle   = 1'b0;
        receiver_throttle = 1'b0;
        hold_request      = 300;
        repeat (150)
            send_char(1);
        sender_throttle   = 1'b1;
        receiver_throttle = 1'b1;
    endtask

    initial
    begin
        error_count       = 0;
        bytes_sent        = 0;
        idle_cycles       = 0;
        hold_request      = 0;
        sender_throttle   = 1'b1;
        receiver_throttle = 1'b1;
        gathered_bits     = '0;
        bytes_left        = '0;
        char_size         = '0;
        rst_n             = 1'b0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_ascii_and_end();
        test_long_forms();
        test_invalid_leads();
        test_malformed_following();
        test_random_stream();
        test_full_rate();
        test_backpressure();

        // drain the remaining results
        s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
rtl/u8dec_pkg.sv
rtl/utf8_stream_decoder.sv
tb/testbench.sv
